>>> rtl/iddt_pkg.sv
package iddt_pkg;

  // S-box index and value width.
  localparam int BITS = 7;
  localparam int SZ = 1 << BITS;

  // Fixed field widths of the ports.
  localparam int MODE_W = 2;
  localparam int POS_W = 7;
  localparam int DIFF_W = 7;

  // Difference table: one entry per (difference, output difference) pair.
  localparam int IDX_W = 2 * BITS;
  localparam int TBL_DEPTH = 1 << IDX_W;

  // Walk counter: the k-th nonzero even-weight difference, k = 1 .. K_LAST.
  localparam int K_W = BITS - 1;
  localparam logic [K_W-1:0] K_LAST = {K_W{1'b1}};

  // Counts are kept in units of two.
  localparam int CNT_W = 2;
  localparam logic [CNT_W-1:0] CNT_ZERO = 2'd0;
  localparam logic [CNT_W-1:0] CNT_PAIR = 2'd1;
  localparam logic [CNT_W-1:0] CNT_MAX = 2'd3;

  localparam logic [MODE_W-1:0] MODE_ASSIGN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_LOOKUP = 4'b0100,
    ST_WALK   = 4'b1000
  } iddt_state_t;

  // Appending the parity of k below k gives the k-th even-weight value,
  // and the mapping keeps ascending order.
  function automatic logic [BITS-1:0] even_diff(input logic [K_W-1:0] k);
    return {k, ^k};
  endfunction

endpackage

>>> rtl/incremental_ddt_apn_checker.sv
// Assign and remove walk the nonzero even-weight differences in ascending order; remove
// first reads the stored value in a lookup state. A conflict ends the walk early, and
// removing an unassigned point answers from the lookup state. One table entry is read,
// updated and written per cycle. Clear zeroes table and S-box; undefined modes answer clean.
// After reset the same clearing pass runs while busy is high, with no result.
// One command runs at a time; results are strobed for one cycle on out_valid, no stall.
module incremental_ddt_apn_checker
  import iddt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [POS_W-1:0]  in_position,
  input  logic [POS_W-1:0]  in_value,
  output logic              out_valid,
  output logic              out_still_apn,
  output logic [DIFF_W-1:0] out_conflict_difference
);

  logic [BITS:0]      sbox_mem [SZ];
  logic [CNT_W-1:0]   tbl_mem  [TBL_DEPTH];

  iddt_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]   clr_r, clr_nxt;
  logic               clr_res_r, clr_res_nxt;
  logic [K_W-1:0]     k_r, k_nxt;
  logic               iss_on_r, iss_on_nxt;
  logic               v1_r, v1_nxt;
  logic               v2_r, v2_nxt;
  logic [BITS-1:0]    a1_r, a1_nxt;
  logic [BITS-1:0]    a2_r, a2_nxt;
  logic [IDX_W-1:0]   t_addr2_r, t_addr2_nxt;
  logic [BITS-1:0]    c_r, c_nxt;
  logic [BITS-1:0]    v_r, v_nxt;
  logic               rm_r, rm_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               ok_r, ok_nxt;
  logic [DIFF_W-1:0]  bad_r, bad_nxt;

  logic [BITS:0]      sb_q;
  logic [CNT_W-1:0]   tb_q;
  logic               sb_we;
  logic [BITS-1:0]    sb_waddr, sb_raddr;
  logic [BITS:0]      sb_wdata;
  logic               tb_we;
  logic [IDX_W-1:0]   tb_waddr, tb_raddr;
  logic [CNT_W-1:0]   tb_wdata;

  logic [BITS-1:0]    pos_in, val_in, a_iss;
  logic [CNT_W-1:0]   cnt_new;
  logic               stop;

  assign pos_in = BITS'(in_position);
  assign val_in = BITS'(in_value);
  assign a_iss  = even_diff(k_r);
  assign tb_raddr = {a1_r, v_r ^ sb_q[BITS-1:0]};

  always_comb begin
    if (rm_r) begin
      cnt_new = (tb_q == CNT_ZERO) ? CNT_ZERO : CNT_W'(tb_q - 1'b1);
    end else begin
      cnt_new = (tb_q == CNT_MAX) ? CNT_MAX : CNT_W'(tb_q + 1'b1);
    end
  end

  // Removal stops once an entry is back to one pair; assignment stops above one pair.
  assign stop = v2_r && (rm_r ? (cnt_new == CNT_PAIR) : (cnt_new > CNT_PAIR));

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    clr_res_nxt   = clr_res_r;
    k_nxt         = k_r;
    iss_on_nxt    = iss_on_r;
    v1_nxt        = 1'b0;
    v2_nxt        = 1'b0;
    a1_nxt        = a1_r;
    a2_nxt        = a2_r;
    t_addr2_nxt   = t_addr2_r;
    c_nxt         = c_r;
    v_nxt         = v_r;
    rm_nxt        = rm_r;
    out_valid_nxt = 1'b0;
    ok_nxt        = ok_r;
    bad_nxt       = bad_r;
    sb_we         = 1'b0;
    sb_waddr      = c_r;
    sb_wdata      = '0;
    sb_raddr      = c_r ^ a_iss;
    tb_we         = 1'b0;
    tb_waddr      = t_addr2_r;
    tb_wdata      = cnt_new;

    case (state_r)
      ST_CLEAR: begin
        tb_we    = 1'b1;
        tb_waddr = clr_r;
        tb_wdata = CNT_ZERO;
        if (clr_r[IDX_W-1:BITS] == '0) begin
          sb_we    = 1'b1;
          sb_waddr = clr_r[BITS-1:0];
        end
        clr_nxt = IDX_W'(clr_r + 1'b1);
        if (clr_r == '1) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = clr_res_r;
          ok_nxt        = 1'b1;
          bad_nxt       = '0;
          clr_res_nxt   = 1'b0;
        end
      end

      ST_IDLE: begin
        sb_raddr = pos_in;
        if (start) begin
          case (in_mode)
            MODE_ASSIGN: begin
              sb_we      = 1'b1;
              sb_waddr   = pos_in;
              sb_wdata   = {1'b1, val_in};
              c_nxt      = pos_in;
              v_nxt      = val_in;
              rm_nxt     = 1'b0;
              k_nxt      = K_W'(1);
              iss_on_nxt = 1'b1;
              state_nxt  = ST_WALK;
            end
            MODE_REMOVE: begin
              c_nxt     = pos_in;
              rm_nxt    = 1'b1;
              state_nxt = ST_LOOKUP;
            end
            MODE_CLEAR: begin
              clr_nxt     = '0;
              clr_res_nxt = 1'b1;
              state_nxt   = ST_CLEAR;
            end
            default: begin
              out_valid_nxt = 1'b1;
              ok_nxt        = 1'b1;
              bad_nxt       = '0;
            end
          endcase
        end
      end

      ST_LOOKUP: begin
        if (sb_q[BITS]) begin
          v_nxt      = sb_q[BITS-1:0];
          k_nxt      = K_W'(1);
          iss_on_nxt = 1'b1;
          state_nxt  = ST_WALK;
        end else begin
          sb_we         = 1'b1;
          out_valid_nxt = 1'b1;
          ok_nxt        = 1'b1;
          bad_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end

      ST_WALK: begin
        // Each difference owns its own table row, so the steps in flight never
        // touch the same entry and need no forwarding.
        if (v2_r) begin
          tb_we = 1'b1;
        end
        if (stop) begin
          iss_on_nxt    = 1'b0;
          out_valid_nxt = 1'b1;
          ok_nxt        = rm_r;
          bad_nxt       = rm_r ? '0 : DIFF_W'(a2_r);
          sb_we         = rm_r;
          state_nxt     = ST_IDLE;
        end else if (!iss_on_r && !v1_r && !v2_r) begin
          out_valid_nxt = 1'b1;
          ok_nxt        = 1'b1;
          bad_nxt       = '0;
          sb_we         = rm_r;
          state_nxt     = ST_IDLE;
        end else begin
          if (iss_on_r) begin
            v1_nxt = 1'b1;
            a1_nxt = a_iss;
            k_nxt  = K_W'(k_r + 1'b1);
            if (k_r == K_LAST) begin
              iss_on_nxt = 1'b0;
            end
          end
          if (v1_r && sb_q[BITS]) begin
            v2_nxt      = 1'b1;
            a2_nxt      = a1_r;
            t_addr2_nxt = tb_raddr;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (sb_we) begin
      sbox_mem[sb_waddr] <= sb_wdata;
    end
    sb_q <= sbox_mem[sb_raddr];
  end

  always_ff @(posedge clk) begin
    if (tb_we) begin
      tbl_mem[tb_waddr] <= tb_wdata;
    end
    tb_q <= tbl_mem[tb_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      clr_res_r   <= 1'b0;
      iss_on_r    <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      clr_res_r   <= clr_res_nxt;
      iss_on_r    <= iss_on_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    a1_r      <= a1_nxt;
    a2_r      <= a2_nxt;
    t_addr2_r <= t_addr2_nxt;
    c_r       <= c_nxt;
    v_r       <= v_nxt;
    rm_r      <= rm_nxt;
    ok_r      <= ok_nxt;
    bad_r     <= bad_nxt;
  end

  assign busy                    = (state_r != ST_IDLE);
  assign out_valid               = out_valid_r;
  assign out_still_apn           = ok_r;
  assign out_conflict_difference = bad_r;

endmodule

>>> rtl/iddt_checker.sv
module iddt_checker
  import iddt_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic [MODE_W-1:0] in_mode,
  input logic              out_valid,
  input logic              out_still_apn,
  input logic [DIFF_W-1:0] out_conflict_difference
);

  // The clearing pass starts right out of reset.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("block not busy after reset");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while busy");

  a_ok_no_diff: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_still_apn) |-> (out_conflict_difference == '0))
    else $error("conflict difference reported without a conflict");

  a_work_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_mode == MODE_ASSIGN || in_mode == MODE_REMOVE ||
                        in_mode == MODE_CLEAR)) |=> busy)
    else $error("accepted command did not raise busy");

  a_undef_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode != MODE_ASSIGN && in_mode != MODE_REMOVE &&
     in_mode != MODE_CLEAR) |=> (out_valid && out_still_apn && !busy))
    else $error("undefined mode did not answer at once");

endmodule

bind incremental_ddt_apn_checker iddt_checker u_iddt_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .start                   (start),
  .busy                    (busy),
  .in_mode                 (in_mode),
  .out_valid               (out_valid),
  .out_still_apn           (out_still_apn),
  .out_conflict_difference (out_conflict_difference)
);

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import iddt_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 70000;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int MAX_GAP = 90;
  localparam logic TYPED = 1'b1;
  localparam logic PREDICT = 1'b0;

  typedef struct packed {
    logic              still_apn;
    logic [DIFF_W-1:0] conflict_diff;
  } apn_verdict_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  val;
    logic              typed;
    apn_verdict_t      want;
  } point_row_t;

  localparam apn_verdict_t CLEAN = '{1'b1, 7'd0};
  localparam int N_DIRECTED = 24;

  // Removes, clears and the undefined mode answer clean; so do assigns into an
  // empty table or at odd-weight distance. The rest go through the predictor.
  point_row_t directed_rows [N_DIRECTED] = '{
    '{MODE_CLEAR,  7'd0,   7'd0,   TYPED,   CLEAN},
    '{MODE_ASSIGN, 7'd0,   7'd0,   TYPED,   CLEAN},
    '{MODE_ASSIGN, 7'd127, 7'd127, TYPED,   CLEAN},
    '{MODE_ASSIGN, 7'd3,   7'd5,   PREDICT, CLEAN},
    '{MODE_ASSIGN, 7'd3,   7'd5,   PREDICT, CLEAN},
    '{MODE_ASSIGN, 7'd3,   7'd5,   PREDICT, CLEAN},
    '{MODE_ASSIGN, 7'd3,   7'd5,   PREDICT, CLEAN},
    '{MODE_REMOVE, 7'd3,   7'd0,   TYPED,   CLEAN},
    '{MODE_REMOVE, 7'd3,   7'd0,   TYPED,   CLEAN},
    '{MODE_REMOVE, 7'd64,  7'd0,   TYPED,   CLEAN},
    '{MODE_UNUSED, 7'd127, 7'd127, TYPED,   CLEAN},
    '{MODE_UNUSED, 7'd0,   7'd0,   TYPED,   CLEAN},
    '{MODE_ASSIGN, 7'd5,   7'd127, PREDICT, CLEAN},
    '{MODE_ASSIGN, 7'd6,   7'd127, PREDICT, CLEAN},
    '{MODE_ASSIGN, 7'd127, 7'd0,   PREDICT, CLEAN},
    '{MODE_ASSIGN, 7'd96,  7'd42,  PREDICT, CLEAN},
    '{MODE_ASSIGN, 7'd85,  7'd85,  PREDICT, CLEAN},
    '{MODE_ASSIGN, 7'd42,  7'd42,  PREDICT, CLEAN},
    '{MODE_REMOVE, 7'd0,   7'd127, TYPED,   CLEAN},
    '{MODE_REMOVE, 7'd127, 7'd0,   TYPED,   CLEAN},
    '{MODE_REMOVE, 7'd5,   7'd0,   TYPED,   CLEAN},
    '{MODE_CLEAR,  7'd127, 7'd127, TYPED,   CLEAN},
    '{MODE_ASSIGN, 7'd0,   7'd127, TYPED,   CLEAN},
    '{MODE_REMOVE, 7'd0,   7'd0,   TYPED,   CLEAN}
  };

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [MODE_W-1:0] in_mode;
  logic [POS_W-1:0]  in_position;
  logic [POS_W-1:0]  in_value;
  logic              out_valid;
  logic              out_still_apn;
  logic [DIFF_W-1:0] out_conflict_difference;

  // Shadow copies of the partial S-box (flag above value) and the table.
  logic [BITS:0]      sbox_model [SZ];
  logic [CNT_W-1:0]   ddt_model [TBL_DEPTH];
  apn_verdict_t       verdicts_due [$];
  int                 mismatches = 0;
  int                 idle_pct = 0;
  int                 quiet_cycles = 0;

  incremental_ddt_apn_checker dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .start                   (start),
    .busy                    (busy),
    .in_mode                 (in_mode),
    .in_position             (in_position),
    .in_value                (in_value),
    .out_valid               (out_valid),
    .out_still_apn           (out_still_apn),
    .out_conflict_difference (out_conflict_difference)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic void clear_stores();
    foreach (sbox_model[i]) sbox_model[i] = '0;
    foreach (ddt_model[i]) ddt_model[i] = CNT_ZERO;
  endfunction

  // Applies one point to the shadow stores and returns the verdict it earns.
  function automatic apn_verdict_t apply_point(input logic [MODE_W-1:0] mode,
                                               input logic [POS_W-1:0] pos,
                                               input logic [POS_W-1:0] val);
    apn_verdict_t     verdict;
    logic [BITS-1:0]  c;
    logic [BITS-1:0]  v;
    logic [BITS-1:0]  d;
    logic [BITS:0]    own;
    logic [BITS:0]    partner;
    logic [IDX_W-1:0] idx;
    verdict = CLEAN;
    c = pos[BITS-1:0];
    v = val[BITS-1:0];
    case (mode)
      MODE_ASSIGN: begin
        sbox_model[c] = {1'b1, v};
        for (int a = 1; a < SZ; a++) begin
          d = a[BITS-1:0];
          if (^d) continue;
          partner = sbox_model[c ^ d];
          if (!partner[BITS]) continue;
          idx = {d, v ^ partner[BITS-1:0]};
          if (ddt_model[idx] != CNT_MAX) ddt_model[idx] = ddt_model[idx] + 1'b1;
          if (ddt_model[idx] > CNT_PAIR) begin
            verdict.still_apn = 1'b0;
            verdict.conflict_diff = DIFF_W'(d);
            break;
          end
        end
      end
      MODE_REMOVE: begin
        own = sbox_model[c];
        if (own[BITS]) begin
          for (int a = 1; a < SZ; a++) begin
            d = a[BITS-1:0];
            if (^d) continue;
            partner = sbox_model[c ^ d];
            if (!partner[BITS]) continue;
            idx = {d, own[BITS-1:0] ^ partner[BITS-1:0]};
            if (ddt_model[idx] != CNT_ZERO) ddt_model[idx] = ddt_model[idx] - 1'b1;
            if (ddt_model[idx] == CNT_PAIR) break;
          end
        end
        sbox_model[c] = '0;
      end
      MODE_CLEAR: clear_stores();
      default: ;
    endcase
    return verdict;
  endfunction

  // Returns an assigned position, starting the search at a random place, or -1.
  function automatic int find_assigned();
    int first;
    first = $urandom_range(SZ - 1);
    for (int i = 0; i < SZ; i++) begin
      if (sbox_model[(first + i) % SZ][BITS]) return (first + i) % SZ;
    end
    return -1;
  endfunction

  // Drives one command, waits for its transfer, and books the expected result.
  task automatic issue_point(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                             input logic [POS_W-1:0] val, input logic typed,
                             input apn_verdict_t typed_want, output apn_verdict_t verdict);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= mode;
    in_position <= pos;
    in_value <= val;
    do @(posedge clk); while (busy);
    verdict = apply_point(mode, pos, val);
    verdicts_due.push_back(typed ? typed_want : verdict);
  endtask

  initial begin : stimulus
    apn_verdict_t      verdict;
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  val;
    int                undo_pos;
    int                pick;
    int                roll;
    clear_stores();
    rst_n <= 1'b0;
    start <= 1'b0;
    in_mode <= MODE_ASSIGN;
    in_position <= '0;
    in_value <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      issue_point(directed_rows[i].mode, directed_rows[i].pos, directed_rows[i].val,
                  directed_rows[i].typed, directed_rows[i].want, verdict);
    end

    // Mostly a search-like walk: keep assigning, and usually back out a point
    // that caused a conflict before going on.
    undo_pos = -1;
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 62 : (phase == 3) ? 29 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pos = POS_W'($urandom_range(SZ - 1));
        val = POS_W'($urandom_range(SZ - 1));
        roll = $urandom_range(99);
        if (undo_pos >= 0 && $urandom_range(4) != 0) begin
          mode = MODE_REMOVE;
          pos = POS_W'(undo_pos);
        end else if (roll < 1) begin
          mode = MODE_CLEAR;
        end else if (roll < 4) begin
          mode = MODE_UNUSED;
        end else if (roll < 22) begin
          mode = MODE_REMOVE;
          pick = find_assigned();
          if (pick >= 0 && $urandom_range(3) != 0) pos = POS_W'(pick);
        end else if (roll < 30) begin
          mode = MODE_ASSIGN;
          pick = find_assigned();
          if (pick >= 0) begin
            pos = POS_W'(pick);
            if ($urandom_range(1) == 1) val = POS_W'(sbox_model[pick][BITS-1:0]);
          end
        end else begin
          mode = MODE_ASSIGN;
        end
        issue_point(mode, pos, val, PREDICT, CLEAN, verdict);
        undo_pos = (mode == MODE_ASSIGN && !verdict.still_apn) ? int'(pos) : -1;
      end
    end
    start <= 1'b0;

    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  always @(posedge clk) begin : result_check
    apn_verdict_t want;
    if (rst_n && out_valid) begin
      if (verdicts_due.size() == 0) begin
        $error("result transfer with no command outstanding");
        mismatches++;
      end else begin
        want = verdicts_due.pop_front();
        if (out_still_apn !== want.still_apn) begin
          $error("still_apn: expected %0d, got %0d", want.still_apn, out_still_apn);
          mismatches++;
        end
        if (out_conflict_difference !== want.conflict_diff) begin
          $error("conflict_difference: expected %0d, got %0d", want.conflict_diff,
                 out_conflict_difference);
          mismatches++;
        end
      end
    end
  end

  // The clearing pass after reset and every clear command are the longest
  // stretches without a transfer; the limit covers them several times over.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
